// ===== rtl/great_circle_distance_nm_assert.svh =====
// Assertion macros for the great-circle distance pipeline
`ifndef GREAT_CIRCLE_DISTANCE_NM_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_NM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GCDN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GCDN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcdn_pkg.sv =====
// Shared constants, tables and helpers for the great-circle distance pipeline
package gcdn_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 22;
  localparam int CORDIC_STAGES_DEF   = 24;

  localparam int LAT_W  = 30;
  localparam int LON_W  = 31;
  localparam int DIST_W = 22;

  localparam int NLANE = 4;
  localparam int MW    = 33;
  localparam int MB_W  = 39;
  localparam int QW    = 34;
  localparam int ANG_W = 32;
  localparam int XW    = 34;
  localparam int AW    = 33;
  localparam int SCW   = 32;
  localparam int SQW   = 62;
  localparam int SQRT_STEPS = 31;
  localparam int ZW    = 34;
  localparam int PRW   = 47;

  localparam logic [MB_W-1:0] DIV_BIAS = MB_W'(64'd45 << 33);
  localparam int              DIV_K    = 29;
  localparam logic [23:0]     DIV_M    = 24'd11930464;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(32'h26DD3B6A);
  localparam logic [30:0]          Q30_ONE     = 31'h4000_0000;

  localparam logic [15:0]       NM_HALF_SCALE = 16'd43200;
  localparam logic [DIST_W-1:0] DIST_MAX      = 22'd2764800;
  localparam logic [DIST_W-1:0] LIMIT_RESET   = 22'd64000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [23:0] q;
    logic [5:0]  r;
  } div45_t;

  function automatic div45_t div45(input logic [23:0] x);
    logic [47:0] p;
    logic [23:0] q0;
    logic [29:0] r0;
    div45_t      d;
    p  = x * DIV_M;
    q0 = 24'(p >> DIV_K);
    r0 = 30'(x) - 30'(q0) * 30'd45;
    if (r0 >= 30'd45) begin
      d.q = q0 + 24'd1;
      d.r = 6'(r0 - 30'd45);
    end else begin
      d.q = q0;
      d.r = 6'(r0);
    end
    return d;
  endfunction

endpackage

// ===== rtl/gcdn_pos_if.sv =====
// Position pair channel: station and aircraft coordinates
interface gcdn_pos_if;
  import gcdn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] station_lat;
  logic signed [LON_W-1:0] station_lon;
  logic signed [LAT_W-1:0] craft_lat;
  logic signed [LON_W-1:0] craft_lon;
  modport source (output valid, station_lat, station_lon, craft_lat, craft_lon, input ready);
  modport sink (input valid, station_lat, station_lon, craft_lat, craft_lon, output ready);
endinterface

// ===== rtl/gcdn_dist_if.sv =====
// Distance result channel
interface gcdn_dist_if;
  import gcdn_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              in_range;
  modport source (output valid, distance, in_range, input ready);
  modport sink (input valid, distance, in_range, output ready);
endinterface

// ===== rtl/great_circle_distance_nm.sv =====
// Great-circle distance pipeline: haversine via CORDIC and pipelined digit-by-digit roots.
// Throughput one beat per cycle; every stage is a register, the whole pipe
// holds while an output beat waits, so ready follows the output register.
// Synchronous reset empties the pipe and loads range_limit with 250 nm.
module great_circle_distance_nm #(
  parameter int ANGLE_FRAC_BITS = gcdn_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = gcdn_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  gcdn_pos_if.sink                    pos,
  gcdn_dist_if.source                 dst,
  input  logic                        cfg_we,
  input  logic [gcdn_pkg::DIST_W-1:0] cfg_wdata
);
  import gcdn_pkg::*;
`include "great_circle_distance_nm_assert.svh"

  localparam int CS  = CORDIC_STAGES;
  localparam int NST = 44 + 2 * CS;
  localparam int S3_DIFF = 28 - ANGLE_FRAC_BITS;
  localparam int S3_ABS  = 29 - ANGLE_FRAC_BITS;

  logic              en;
  logic [NST-1:0]    vld;
  logic [DIST_W-1:0] range_limit;

  assign en        = !vld[NST-1] || dst.ready;
  assign pos.ready = en;
  assign dst.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], pos.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      range_limit <= cfg_wdata;
    end
  end

  // binary-angle conversion
  logic signed [MW-1:0]   m    [NLANE];
  logic [MB_W-1:0]        mb   [NLANE];
  logic [23:0]            qh   [NLANE];
  logic [5:0]             rh   [NLANE];
  logic [15:0]            ml   [NLANE];
  logic [QW-1:0]          qv   [NLANE];
  logic [5:0]             rl   [NLANE];
  logic [ANG_W-1:0]       bam  [NLANE];

  // rotation CORDIC
  logic signed [XW-1:0]   rx   [NLANE][CS+1];
  logic signed [XW-1:0]   ry   [NLANE][CS+1];
  logic signed [AW-1:0]   ra   [NLANE][CS+1];
  logic                   rneg [NLANE][CS+1];
  logic signed [SCW-1:0]  sinv [NLANE];
  logic signed [SCW-1:0]  cosv [NLANE];

  assign m[0] = MW'(pos.station_lat) - MW'(pos.craft_lat);
  assign m[1] = MW'(pos.station_lon) - MW'(pos.craft_lon);
  assign m[2] = MW'(pos.station_lat);
  assign m[3] = MW'(pos.craft_lat);

  genvar l, k;
  generate
    for (l = 0; l < NLANE; l++) begin : g_lane
      localparam int S3 = (l < 2) ? S3_DIFF : S3_ABS;
      div45_t                d1, d2, d3;
      logic signed [AW-1:0]  as;
      logic signed [AW-1:0]  ared;
      logic                  nred;
      logic signed [XW-1:0]  xf, yf;

      assign d1 = div45(24'(mb[l][MB_W-1:16]));
      assign d2 = div45(24'({rh[l], ml[l]}));
      assign d3 = div45(24'(rl[l]) << S3);
      assign as = AW'($signed(bam[l]));

      always_comb begin
        ared = as;
        nred = 1'b0;
        if (as > $signed(AW'(Q30_ONE))) begin
          ared = as - (AW'(Q30_ONE) <<< 1);
          nred = 1'b1;
        end else if (as < -$signed(AW'(Q30_ONE))) begin
          ared = as + (AW'(Q30_ONE) <<< 1);
          nred = 1'b1;
        end
      end

      assign xf = rneg[l][CS] ? -rx[l][CS] : rx[l][CS];
      assign yf = rneg[l][CS] ? -ry[l][CS] : ry[l][CS];

      always_ff @(posedge clk) begin
        if (en) begin
          mb[l]      <= MB_W'(m[l]) + DIV_BIAS;
          qh[l]      <= d1.q;
          rh[l]      <= d1.r;
          ml[l]      <= mb[l][15:0];
          qv[l]      <= (QW'(qh[l]) << 16) | QW'(d2.q[15:0]);
          rl[l]      <= d2.r;
          bam[l]     <= ANG_W'(qv[l] << S3) + ANG_W'(d3.q);
          rx[l][0]   <= CORDIC_GAIN;
          ry[l][0]   <= '0;
          ra[l][0]   <= ared;
          rneg[l][0] <= nred;
          if (xf > $signed(XW'(Q30_ONE))) begin
            cosv[l] <= SCW'(Q30_ONE);
          end else if (xf < -$signed(XW'(Q30_ONE))) begin
            cosv[l] <= -SCW'(Q30_ONE);
          end else begin
            cosv[l] <= SCW'(xf);
          end
          if (yf > $signed(XW'(Q30_ONE))) begin
            sinv[l] <= SCW'(Q30_ONE);
          end else if (yf < -$signed(XW'(Q30_ONE))) begin
            sinv[l] <= -SCW'(Q30_ONE);
          end else begin
            sinv[l] <= SCW'(yf);
          end
        end
      end

      for (k = 0; k < CS; k++) begin : g_rot
        localparam logic signed [AW-1:0] ATN = $signed({1'b0, ATAN_TAB[k]});
        always_ff @(posedge clk) begin
          if (en) begin
            rneg[l][k+1] <= rneg[l][k];
            if (ra[l][k] >= 0) begin
              rx[l][k+1] <= rx[l][k] - (ry[l][k] >>> k);
              ry[l][k+1] <= ry[l][k] + (rx[l][k] >>> k);
              ra[l][k+1] <= ra[l][k] - ATN;
            end else begin
              rx[l][k+1] <= rx[l][k] + (ry[l][k] >>> k);
              ry[l][k+1] <= ry[l][k] - (rx[l][k] >>> k);
              ra[l][k+1] <= ra[l][k] + ATN;
            end
          end
        end
      end
    end
  endgenerate

  // haversine
  logic signed [63:0]    p_a, p_b, p_c, p_cb;
  logic [30:0]           sq_a, sq_b, hs_a, h;
  logic signed [SCW-1:0] cc, cbv;
  logic signed [SCW:0]   hsum;
  logic [SQW-1:0]        sq_rem [2][SQRT_STEPS+1];
  logic [SQW-1:0]        sq_res [2][SQRT_STEPS+1];

  assign p_a  = sinv[0] * sinv[0];
  assign p_b  = sinv[1] * sinv[1];
  assign p_c  = cosv[2] * cosv[3];
  assign p_cb = cc * $signed({1'b0, sq_b});
  assign hsum = (SCW+1)'($signed({1'b0, hs_a})) + (SCW+1)'(cbv);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a <= 31'(p_a >>> 30);
      sq_b <= 31'(p_b >>> 30);
      cc   <= SCW'(p_c >>> 30);
      hs_a <= sq_a;
      cbv  <= SCW'(p_cb >>> 30);
      if (hsum < 0) begin
        h <= '0;
      end else if (hsum > (SCW+1)'(Q30_ONE)) begin
        h <= Q30_ONE;
      end else begin
        h <= 31'(hsum);
      end
      sq_rem[0][0] <= SQW'({h, 30'b0});
      sq_rem[1][0] <= SQW'({31'(Q30_ONE - h), 30'b0});
      sq_res[0][0] <= '0;
      sq_res[1][0] <= '0;
    end
  end

  genvar j, r;
  generate
    for (r = 0; r < 2; r++) begin : g_root
      for (j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [SQW-1:0] trial;
        assign trial = sq_res[r][j] + BIT;
        always_ff @(posedge clk) begin
          if (en) begin
            if (sq_rem[r][j] >= trial) begin
              sq_rem[r][j+1] <= sq_rem[r][j] - trial;
              sq_res[r][j+1] <= (sq_res[r][j] >> 1) + BIT;
            end else begin
              sq_rem[r][j+1] <= sq_rem[r][j];
              sq_res[r][j+1] <= sq_res[r][j] >> 1;
            end
          end
        end
      end
    end
  endgenerate

  // vectoring CORDIC and scaling
  logic signed [XW-1:0] vx [CS+1];
  logic signed [XW-1:0] vy [CS+1];
  logic signed [ZW-1:0] vz [CS+1];
  logic [30:0]          zc;
  logic [PRW-1:0]       prod;
  logic [PRW:0]         rnd;
  logic [23:0]          dq;
  logic [DIST_W-1:0]    dist_next;

  always_comb begin
    vx[0] = $signed(XW'(sq_res[1][SQRT_STEPS][30:0]));
    vy[0] = $signed(XW'(sq_res[0][SQRT_STEPS][30:0]));
    vz[0] = '0;
  end

  generate
    for (k = 0; k < CS; k++) begin : g_vec
      localparam logic signed [ZW-1:0] ATN = $signed(ZW'(ATAN_TAB[k]));
      logic signed [XW-1:0] ix, iy;
      logic signed [ZW-1:0] iz;
      if (k == 0) begin : g_first
        assign ix = vx[0];
        assign iy = vy[0];
        assign iz = vz[0];
      end else begin : g_rest
        assign ix = vx[k];
        assign iy = vy[k];
        assign iz = vz[k];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (iy > 0) begin
            vx[k+1] <= ix + (iy >>> k);
            vy[k+1] <= iy - (ix >>> k);
            vz[k+1] <= iz + ATN;
          end else begin
            vx[k+1] <= ix - (iy >>> k);
            vy[k+1] <= iy + (ix >>> k);
            vz[k+1] <= iz - ATN;
          end
        end
      end
    end
  endgenerate

  assign rnd       = (PRW+1)'(prod) + ((PRW+1)'(1) << 23);
  assign dq        = 24'(rnd >> 24);
  assign dist_next = (dq > 24'(DIST_MAX)) ? DIST_MAX : DIST_W'(dq);

  always_ff @(posedge clk) begin
    if (en) begin
      if (vz[CS] < 0) begin
        zc <= '0;
      end else if (vz[CS] > ZW'(Q30_ONE)) begin
        zc <= Q30_ONE;
      end else begin
        zc <= 31'(vz[CS]);
      end
      prod         <= PRW'(zc) * PRW'(NM_HALF_SCALE);
      dst.distance <= dist_next;
      dst.in_range <= dist_next < range_limit;
    end
  end

  `GCDN_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(vld), "pipe moved while stalled")
  `GCDN_ASSERT_NEXT(a_accept_enters, clk, rst, pos.valid && pos.ready, vld[0], "accepted beat lost")
  `GCDN_ASSERT_NOW(a_dist_max, clk, rst, dst.valid, dst.distance <= DIST_MAX, "distance above max")

endmodule
